>>> rtl/core/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared widths, register indexes, fixed-point constants and a helper for the
// PID controller with back-calculation antiwindup.
// ----------------------------------------------------------------------------
package pidaw_pkg;

   // payload widths
   localparam int TEMP_W     = 12;
   localparam int DRIVE_W    = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // datapath widths: shared 33x33 signed multiplier, 66-bit accumulator
   localparam int MUL_W  = 33;
   localparam int ACC_W  = 2 * MUL_W;
   localparam int STATE_W = 48;
   localparam int USAT_W = 31;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BI   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AD   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BD   = 3'd4;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] KP_RESET   = 32'd1100726;
   localparam logic [CSR_DATA_W-1:0] BETA_RESET = 32'd6554;

   // 1/0.99 in Q16.16
   localparam logic signed [MUL_W-1:0] BACKCALC_Q16 = 33'sd66198;

   // valid measurement window, exclusive, 1/16 degree
   localparam logic signed [TEMP_W-1:0] TEMP_LOW  = 12'sd0;
   localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 12'sd1600;

   // 100 percent in 2^-24 units, and in 1/256 units
   localparam logic [USAT_W-1:0]  FULL_DRIVE = 31'd1677721600;
   localparam logic [DRIVE_W-1:0] DRIVE_MAX  = 15'd25600;

   // saturate an accumulator value to signed 48 bits
   function automatic logic signed [STATE_W-1:0] sat48(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] hi_lim;
      logic signed [ACC_W-1:0] lo_lim;
      hi_lim = $signed({{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}});
      lo_lim = $signed({{(ACC_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}});
      if (x > hi_lim) begin
         sat48 = hi_lim[STATE_W-1:0];
      end else if (x < lo_lim) begin
         sat48 = lo_lim[STATE_W-1:0];
      end else begin
         sat48 = x[STATE_W-1:0];
      end
   endfunction

endpackage

>>> rtl/core/pidaw_req_if.sv
// ----------------------------------------------------------------------------
// pidaw_req_if
// Sample channel: restart flag, setpoint and measured temperature.
// ----------------------------------------------------------------------------
interface pidaw_req_if;
   import pidaw_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     restart;
   logic signed [TEMP_W-1:0] setpoint;
   logic signed [TEMP_W-1:0] measured_temp;

   modport source (output valid, output restart, output setpoint, output measured_temp,
                   input ready);
   modport sink   (input valid, input restart, input setpoint, input measured_temp,
                   output ready);
endinterface

>>> rtl/core/pidaw_rsp_if.sv
// ----------------------------------------------------------------------------
// pidaw_rsp_if
// Result channel: saturated heater drive and fault flag.
// ----------------------------------------------------------------------------
interface pidaw_rsp_if;
   import pidaw_pkg::*;

   logic               valid;
   logic               ready;
   logic [DRIVE_W-1:0] drive;
   logic               fault;

   modport source (output valid, output drive, output fault, input ready);
   modport sink   (input valid, input drive, input fault, output ready);
endinterface

>>> rtl/core/pidaw_csr_if.sv
// ----------------------------------------------------------------------------
// pidaw_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pidaw_csr_if;
   import pidaw_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/pid_controller_antiwindup_unit.sv
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_unit
// A normal sample runs the sequencer from ST_MBR through ST_COMMIT to ST_DONE,
// which loads the result beat; a faulted sample goes straight to ST_DONE; a
// restart beat gives no result and leaves the unit idle. A new sample is taken
// only once the last result is loaded: the sequencer runs all eight products
// through one registered 33x33 multiplier; a stalled result beat holds the sequencer.
// Reset (synchronous): registers to defaults, integral, derivative, previous
// temperature and fault cleared; no result pending. Register writes: always ready.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_unit (
   input  logic               clock,
   input  logic               reset,
   pidaw_req_if.sink          req_ch,
   pidaw_rsp_if.source        rsp_ch,
   pidaw_csr_if.sink          csr_ch
);
   import pidaw_pkg::*;

   // sequencer states
   typedef enum logic [16:0] {
      ST_IDLE   = 17'h00001,
      ST_MBR    = 17'h00002,
      ST_SUBY   = 17'h00004,
      ST_MKP    = 17'h00008,
      ST_MDH    = 17'h00010,
      ST_MDL    = 17'h00020,
      ST_MBD    = 17'h00040,
      ST_MBI    = 17'h00080,
      ST_DSAT   = 17'h00100,
      ST_USUM   = 17'h00200,
      ST_CLMP   = 17'h00400,
      ST_DIFF   = 17'h00800,
      ST_MXH    = 17'h01000,
      ST_MXL    = 17'h02000,
      ST_IACC   = 17'h04000,
      ST_COMMIT = 17'h08000,
      ST_DONE   = 17'h10000
   } seq_state_type;

   localparam logic signed [ACC_W-1:0] FULL_ACC =
      $signed({{(ACC_W-USAT_W){1'b0}}, FULL_DRIVE});

   // configuration registers
   logic signed [CSR_DATA_W-1:0] kp_ff, beta_ff, bi_ff, ad_ff, bd_ff;

   // control state
   seq_state_type             state_ff, state_in;
   logic signed [STATE_W-1:0] integral_ff, integral_in;
   logic signed [STATE_W-1:0] deriv_ff, deriv_in;
   logic signed [TEMP_W-1:0]  prev_ff, prev_in;
   logic                      fault_ff, fault_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // payload / datapath registers
   logic signed [TEMP_W-1:0]  r_ff, r_in;
   logic signed [TEMP_W-1:0]  y_ff, y_in;
   logic                      res_fault_ff, res_fault_in;
   logic signed [ACC_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W-1:0]   p_ff, p_in;
   logic signed [ACC_W-1:0]   t_ff, t_in;
   logic signed [STATE_W-1:0] d_ff, d_in;
   logic signed [STATE_W-1:0] x_ff, x_in;
   logic [USAT_W-1:0]         usat_ff, usat_in;
   logic [DRIVE_W-1:0]        rsp_drive_ff, rsp_drive_in;
   logic                      rsp_fault_ff, rsp_fault_in;

   // shared multiplier operands
   logic signed [MUL_W-1:0]   mul_a, mul_b;

   logic signed [TEMP_W:0]    dy;
   logic signed [TEMP_W:0]    err;
   logic signed [ACC_W-1:0]   integral_ext;
   logic signed [ACC_W-1:0]   y_shift;
   logic                      out_of_range;
   logic                      slot_free;

   // handshakes
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.drive = rsp_drive_ff;
   assign rsp_ch.fault = rsp_fault_ff;

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign out_of_range = (req_ch.measured_temp <= TEMP_LOW) ||
                         (req_ch.measured_temp >= TEMP_HIGH);

   // sign-extended helpers
   assign dy  = $signed({y_ff[TEMP_W-1], y_ff}) - $signed({prev_ff[TEMP_W-1], prev_ff});
   assign err = $signed({r_ff[TEMP_W-1], r_ff}) - $signed({y_ff[TEMP_W-1], y_ff});
   assign integral_ext = $signed({{(ACC_W-STATE_W){integral_ff[STATE_W-1]}}, integral_ff});
   assign y_shift = $signed({{(ACC_W-TEMP_W-16){y_ff[TEMP_W-1]}}, y_ff, 16'b0});

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff   <= $signed(KP_RESET);
         beta_ff <= $signed(BETA_RESET);
         bi_ff   <= '0;
         ad_ff   <= '0;
         bd_ff   <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_KP:   kp_ff   <= $signed(csr_ch.data);
            CSR_BETA: beta_ff <= $signed(csr_ch.data);
            CSR_BI:   bi_ff   <= $signed(csr_ch.data);
            CSR_AD:   ad_ff   <= $signed(csr_ch.data);
            CSR_BD:   bd_ff   <= $signed(csr_ch.data);
            default: ;
         endcase
      end
   end

   // sequencer and datapath: a product issued in one state is consumed in the next
   always_comb begin
      state_in     = state_ff;
      integral_in  = integral_ff;
      deriv_in     = deriv_ff;
      prev_in      = prev_ff;
      fault_in     = fault_ff;
      rsp_valid_in = rsp_valid_ff;
      r_in         = r_ff;
      y_in         = y_ff;
      res_fault_in = res_fault_ff;
      acc_in       = acc_ff;
      p_in         = p_ff;
      t_in         = t_ff;
      d_in         = d_ff;
      x_in         = x_ff;
      usat_in      = usat_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_fault_in = rsp_fault_ff;
      mul_a        = '0;
      mul_b        = '0;

      // result beat taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.restart) begin
                  integral_in = '0;
                  fault_in    = 1'b0;
               end else begin
                  r_in = req_ch.setpoint;
                  y_in = req_ch.measured_temp;
                  if (fault_ff || out_of_range) begin
                     fault_in     = 1'b1;
                     res_fault_in = 1'b1;
                     state_in     = ST_DONE;
                  end else begin
                     res_fault_in = 1'b0;
                     state_in     = ST_MBR;
                  end
               end
            end
         end
         // beta * r
         ST_MBR: begin
            mul_a    = MUL_W'(beta_ff);
            mul_b    = MUL_W'(r_ff);
            state_in = ST_SUBY;
         end
         // beta*r - y*2^16
         ST_SUBY: begin
            acc_in   = prod_ff - y_shift;
            state_in = ST_MKP;
         end
         // kp * floor(.../2^12)
         ST_MKP: begin
            mul_a    = MUL_W'(kp_ff);
            mul_b    = acc_ff[MUL_W+11:12];
            state_in = ST_MDH;
         end
         // ad * high part of the derivative state
         ST_MDH: begin
            p_in     = prod_ff;
            mul_a    = MUL_W'(ad_ff);
            mul_b    = $signed({deriv_ff[STATE_W-1], deriv_ff[STATE_W-1:16]});
            state_in = ST_MDL;
         end
         // ad * low 16 bits of the derivative state
         ST_MDL: begin
            acc_in   = prod_ff;
            mul_a    = MUL_W'(ad_ff);
            mul_b    = $signed({{(MUL_W-16){1'b0}}, deriv_ff[15:0]});
            state_in = ST_MBD;
         end
         // bd * (y - y_prev)
         ST_MBD: begin
            acc_in   = acc_ff + (prod_ff >>> 16);
            mul_a    = MUL_W'(bd_ff);
            mul_b    = MUL_W'(dy);
            state_in = ST_MBI;
         end
         // bi * (r - y)
         ST_MBI: begin
            acc_in   = acc_ff - (prod_ff <<< 4);
            mul_a    = MUL_W'(bi_ff);
            mul_b    = MUL_W'(err);
            state_in = ST_DSAT;
         end
         // new derivative state; start u = P + I
         ST_DSAT: begin
            d_in     = sat48(acc_ff);
            t_in     = prod_ff;
            acc_in   = p_ff + integral_ext;
            state_in = ST_USUM;
         end
         // u = P + I + D
         ST_USUM: begin
            acc_in   = acc_ff + $signed({{(ACC_W-STATE_W){d_ff[STATE_W-1]}}, d_ff});
            state_in = ST_CLMP;
         end
         // clamp to 0..100 percent
         ST_CLMP: begin
            if (acc_ff < 0) begin
               usat_in = '0;
            end else if (acc_ff > FULL_ACC) begin
               usat_in = FULL_DRIVE;
            end else begin
               usat_in = acc_ff[USAT_W-1:0];
            end
            state_in = ST_DIFF;
         end
         // saturation error usat - u
         ST_DIFF: begin
            x_in     = sat48($signed({{(ACC_W-USAT_W){1'b0}}, usat_ff}) - acc_ff);
            state_in = ST_MXH;
         end
         // back-calculation, high part; start I + bi*(r-y)*16
         ST_MXH: begin
            acc_in   = integral_ext + (t_ff <<< 4);
            mul_a    = BACKCALC_Q16;
            mul_b    = $signed({x_ff[STATE_W-1], x_ff[STATE_W-1:16]});
            state_in = ST_MXL;
         end
         // back-calculation, low part
         ST_MXL: begin
            acc_in   = acc_ff + prod_ff;
            mul_a    = BACKCALC_Q16;
            mul_b    = $signed({{(MUL_W-16){1'b0}}, x_ff[15:0]});
            state_in = ST_IACC;
         end
         ST_IACC: begin
            acc_in   = acc_ff + (prod_ff >>> 16);
            state_in = ST_COMMIT;
         end
         // update controller state
         ST_COMMIT: begin
            integral_in = sat48(acc_ff);
            deriv_in    = d_ff;
            prev_in     = y_ff;
            state_in    = ST_DONE;
         end
         // load the result register once it is free
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_fault_in = res_fault_ff;
               rsp_drive_in = res_fault_ff ? '0 : usat_ff[USAT_W-1:16];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         integral_ff  <= '0;
         deriv_ff     <= '0;
         prev_ff      <= '0;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         integral_ff  <= integral_in;
         deriv_ff     <= deriv_in;
         prev_ff      <= prev_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers and shared multiplier
   always_ff @(posedge clock) begin
      prod_ff      <= mul_a * mul_b;
      r_ff         <= r_in;
      y_ff         <= y_in;
      res_fault_ff <= res_fault_in;
      acc_ff       <= acc_in;
      p_ff         <= p_in;
      t_ff         <= t_in;
      d_ff         <= d_in;
      x_ff         <= x_in;
      usat_ff      <= usat_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   // checks
   a_fault_zero_drive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fault_ff) |-> (rsp_drive_ff == '0))
      else $error("fault result with nonzero drive");

   a_drive_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_drive_ff <= DRIVE_MAX))
      else $error("drive above full scale");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.restart) |=>
         (!fault_ff && integral_ff == '0 && state_ff == ST_IDLE))
      else $error("restart did not clear integral and fault");

   a_state_hold_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_COMMIT && state_ff != ST_IDLE) |=> $stable(deriv_ff))
      else $error("derivative state changed outside commit");

endmodule
